### sv/mexp_pkg.sv
// Shared types and constants for the modular exponentiation core.
// No dependencies; compile first.
package mexp_pkg;

  // Width of the base field of an input beat
  localparam int unsigned BASE_WIDTH = 30;

  // Modulus after reset (a prime)
  localparam logic [31:0] MOD_RESET = 32'd998244353;

  // Status of the bit-serial modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mexp_mul_status_t;

endpackage

### sv/mexp_ifs.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on mexp_pkg for the base field width.
interface mexp_req_if import mexp_pkg::*; #(
  parameter int unsigned EXP_WIDTH = 63
);
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [BASE_WIDTH-1:0] base;
  logic [EXP_WIDTH-1:0]  exponent;

  modport source (output valid, output op, output base, output exponent, input ready);
  modport sink (input valid, input op, input base, input exponent, output ready);
endinterface

interface mexp_rsp_if #(
  parameter int unsigned MOD_WIDTH = 30
);
  logic                 valid;
  logic                 ready;
  logic [MOD_WIDTH-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

### sv/mexp_modmul.sv
// Bit-serial interleaved modular multiplier: p = x * y mod m, one bit of y per cycle.
// Depends on mexp_pkg (status struct). Requires x < m and m >= 2; y may be any value.
module mexp_modmul import mexp_pkg::*; #(
  parameter int unsigned MOD_WIDTH = 30,
  parameter int unsigned Y_WIDTH   = 30
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [MOD_WIDTH-1:0] x_i,
  input  logic [Y_WIDTH-1:0]   y_i,
  input  logic [MOD_WIDTH-1:0] m_i,
  output mexp_mul_status_t     status_o,
  output logic [MOD_WIDTH-1:0] p_o
);

  localparam int unsigned EW = MOD_WIDTH + 3;
  localparam int unsigned CW = $clog2(Y_WIDTH + 1);

  logic [MOD_WIDTH-1:0] acc_q;
  logic [MOD_WIDTH-1:0] x_q;
  logic [Y_WIDTH-1:0]   y_q;
  logic [CW-1:0]        cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [EW-1:0] two;
  logic [EW-1:0] xe;
  logic [EW-1:0] me;
  logic [EW-1:0] s_a;
  logic [EW-1:0] s_x;
  logic [EW-1:0] s_b;
  logic [EW-1:0] s_c;
  logic [EW-1:0] nxt;

  // Candidates for 2*acc (+x) folded back into [0, m); top bit is the sign
  assign two = {2'b00, acc_q, 1'b0};
  assign xe  = EW'(x_q);
  assign me  = EW'(m_i);
  assign s_a = two - me;
  assign s_x = two + xe;
  assign s_b = s_x - me;
  assign s_c = s_x - {me[EW-2:0], 1'b0};

  // Pick the one candidate that lies in range
  always_comb begin
    if (y_q[Y_WIDTH-1]) begin
      if (!s_c[EW-1]) begin
        nxt = s_c;
      end else if (!s_b[EW-1]) begin
        nxt = s_b;
      end else begin
        nxt = s_x;
      end
    end else begin
      if (!s_a[EW-1]) begin
        nxt = s_a;
      end else begin
        nxt = two;
      end
    end
  end

  // Load operands, then shift y out MSB first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      x_q    <= '0;
      y_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      // Flag done for one cycle after the last bit
      done_q <= !start_i && busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        acc_q  <= '0;
        x_q    <= x_i;
        y_q    <= y_i;
        cnt_q  <= CW'(Y_WIDTH);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q <= nxt[MOD_WIDTH-1:0];
        y_q   <= y_q << 1;
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign status_o = '{busy: busy_q, done: done_q};
  assign p_o      = acc_q;

  a_busy_has_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("multiplier busy with no bits left");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("multiplier done while still busy");

  a_finish_flags_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> done_q)
    else $error("multiplier stopped without done");

endmodule

### sv/modular_exponentiation_core.sv
// Modular exponentiation core: right-to-left square-and-multiply on a bit-serial multiplier.
// Depends on mexp_pkg, mexp_ifs (mexp_req_if, mexp_rsp_if) and mexp_modmul.
//
//   channel   dir  handshake      payload
//   req_i     in   valid/ready    op, base, exponent
//   rsp_o     out  valid/ready    result
//   modulus   in   modulus_we_i   modulus_i (write only)
//
// Every multiply runs on the one bit-serial multiplier, whose y operand is Y_W bits wide,
// Y_W = max(30, MOD_WIDTH). An item costs one base reduction, then per exponent bit up to
// the highest set bit one step state, one square and one more multiply where the bit is 1;
// the last square is dropped. A modulus below two skips all multiplies and gives zero.
// Reset loads the modulus with 998244353 and empties the core; no clearing pass.
// One item is worked at a time; a held result does not stop the next item from entering,
// but that item waits in its finish state until the held result leaves.
module modular_exponentiation_core import mexp_pkg::*; #(
  parameter int unsigned MOD_WIDTH = 30,
  parameter int unsigned EXP_WIDTH = 63
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mexp_req_if.sink             req_i,
  mexp_rsp_if.source           rsp_o,
  input  logic                 modulus_we_i,
  input  logic [MOD_WIDTH-1:0] modulus_i
);

  localparam int unsigned Y_W = (BASE_WIDTH > MOD_WIDTH) ? BASE_WIDTH : MOD_WIDTH;
  localparam int unsigned X_W = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_MULT,
    ST_SQR,
    ST_FIN
  } state_e;

  state_e               state_q;
  logic [MOD_WIDTH-1:0] modulus_q;
  logic [MOD_WIDTH-1:0] acc_q;
  logic [MOD_WIDTH-1:0] sq_q;
  logic [X_W-1:0]       exp_q;
  logic [MOD_WIDTH-1:0] result_q;
  logic                 out_valid_q;
  logic                 mul_start_q;
  logic                 mul_start_d;
  logic [MOD_WIDTH-1:0] mul_x_q;
  logic [Y_W-1:0]       mul_y_q;

  mexp_mul_status_t     mul_status;
  logic [MOD_WIDTH-1:0] mul_p;
  logic                 req_beat;
  logic                 rsp_beat;
  logic                 mod_small;
  logic                 fin_load;

  assign req_beat  = req_i.valid && req_i.ready;
  assign rsp_beat  = rsp_o.valid && rsp_o.ready;
  assign mod_small = (modulus_q[MOD_WIDTH-1:1] == '0);
  assign fin_load  = (state_q == ST_FIN) && (!out_valid_q || rsp_o.ready);

  assign req_i.ready  = (state_q == ST_IDLE);
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.result = result_q;

  // Hold the modulus register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MOD_WIDTH'(MOD_RESET);
    end else if (modulus_we_i) begin
      modulus_q <= modulus_i;
    end
  end

  mexp_modmul #(
    .MOD_WIDTH (MOD_WIDTH),
    .Y_WIDTH   (Y_W)
  ) u_modmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start_q),
    .x_i      (mul_x_q),
    .y_i      (mul_y_q),
    .m_i      (modulus_q),
    .status_o (mul_status),
    .p_o      (mul_p)
  );

  // Pulse the multiplier start on each edge that enters a multiply state
  always_comb begin
    case (state_q)
      ST_IDLE: mul_start_d = req_beat && !mod_small;
      ST_STEP: mul_start_d = (exp_q != '0);
      ST_MULT: mul_start_d = mul_status.done && (exp_q[X_W-1:1] != '0);
      default: mul_start_d = 1'b0;
    endcase
  end

  // Sequence reduction, multiplies and squares; hold the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      sq_q        <= '0;
      exp_q       <= '0;
      result_q    <= '0;
      out_valid_q <= 1'b0;
      mul_start_q <= 1'b0;
      mul_x_q     <= '0;
      mul_y_q     <= '0;
    end else begin
      mul_start_q <= mul_start_d;
      // Raise valid when a result is loaded, drop it on the result beat
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_beat) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_beat) begin
            exp_q <= req_i.op ? X_W'(modulus_q - MOD_WIDTH'(2)) : X_W'(req_i.exponent);
            if (mod_small) begin
              acc_q   <= '0;
              state_q <= ST_FIN;
            end else begin
              // Reduce the base as 1 * base mod m
              acc_q       <= MOD_WIDTH'(1);
              mul_x_q     <= MOD_WIDTH'(1);
              mul_y_q     <= Y_W'(req_i.base);
              state_q     <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (mul_status.done) begin
            sq_q    <= mul_p;
            state_q <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (exp_q == '0) begin
            state_q <= ST_FIN;
          end else if (exp_q[0]) begin
            mul_x_q <= acc_q;
            mul_y_q <= Y_W'(sq_q);
            state_q <= ST_MULT;
          end else begin
            mul_x_q <= sq_q;
            mul_y_q <= Y_W'(sq_q);
            state_q <= ST_SQR;
          end
        end
        ST_MULT: begin
          if (mul_status.done) begin
            acc_q <= mul_p;
            // Drop the final square once no exponent bits remain
            if (exp_q[X_W-1:1] == '0) begin
              state_q <= ST_FIN;
            end else begin
              mul_x_q     <= sq_q;
              mul_y_q     <= Y_W'(sq_q);
              state_q     <= ST_SQR;
            end
          end
        end
        ST_SQR: begin
          if (mul_status.done) begin
            sq_q    <= mul_p;
            exp_q   <= exp_q >> 1;
            state_q <= ST_STEP;
          end
        end
        ST_FIN: begin
          if (fin_load) begin
            result_q    <= acc_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start_q |-> !mul_status.busy)
    else $error("multiply started while multiplier busy");

  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_status.done |-> (state_q == ST_REDUCE || state_q == ST_MULT || state_q == ST_SQR))
    else $error("multiplier finished with no multiply pending");

  a_load_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result register loaded outside finish state");

endmodule

### dv/modular_exponentiation_core_tb.sv
// Self-checking testbench for modular_exponentiation_core: power and Fermat inverse beats.
// Depends on mexp_pkg, mexp_ifs and the core; predicts results with its own scoreboard.
module modular_exponentiation_core_tb;
  import mexp_pkg::*;

  localparam int unsigned MOD_W         = 30;
  localparam int unsigned EXP_W         = 63;
  localparam int unsigned ITEMS_PER_SET = 20;
  localparam int unsigned NUM_SETS      = 6;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned STALL_LIMIT   = 50000;

  localparam logic [MOD_W-1:0] MOD_MAX   = '1;
  localparam logic [MOD_W-1:0] PRIME_TOP = 30'd1073741789;
  localparam logic [MOD_W-1:0] PRIME_1E9 = 30'd1000000007;
  localparam logic [MOD_W-1:0] PRIME_F4  = 30'd65537;

  typedef enum logic {
    OP_POWER   = 1'b0,
    OP_INVERSE = 1'b1
  } mexp_op_e;

  // Expected-result store with its own copy of the modulus register
  class mexp_scoreboard;
    logic [MOD_W-1:0] modulus;
    logic [MOD_W-1:0] expected_q[$];
    int unsigned      n_errors;

    function new();
      modulus  = MOD_RESET[MOD_W-1:0];
      n_errors = 0;
    endfunction

    function void set_modulus(logic [MOD_W-1:0] value);
      modulus = value;
    endfunction

    // Right-to-left square and multiply; products stay below 2^60
    function logic [MOD_W-1:0] power_mod(logic [63:0] b, logic [63:0] e);
      logic [63:0] m;
      logic [63:0] acc;
      logic [63:0] sq;
      m = 64'(modulus);
      if (m < 2) return '0;
      acc = 64'd1;
      sq  = b % m;
      while (e != 0) begin
        if (e[0]) acc = (acc * sq) % m;
        sq = (sq * sq) % m;
        e  = e >> 1;
      end
      return acc[MOD_W-1:0];
    endfunction

    function void note_request(mexp_op_e op, logic [BASE_WIDTH-1:0] base,
                               logic [EXP_W-1:0] exponent);
      logic [MOD_W-1:0] r;
      if (op == OP_INVERSE) begin
        if (modulus < 2) r = '0;
        else r = power_mod(64'(base), 64'(modulus) - 64'd2);
      end else begin
        r = power_mod(64'(base), 64'(exponent));
      end
      expected_q = {expected_q, r};
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      n_errors++;
    endtask

    task check_result(logic [MOD_W-1:0] got);
      logic [MOD_W-1:0] want;
      if (expected_q.size() == 0) begin
        report($sformatf("result beat 0x%08h with nothing pending", got));
      end else begin
        want = expected_q.pop_front();
        if (got !== want)
          report($sformatf("result 0x%08h, predicted 0x%08h", got, want));
      end
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic             modulus_we_i;
  logic [MOD_W-1:0] modulus_i;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles = 0;

  mexp_scoreboard sb;

  mexp_req_if #(.EXP_WIDTH(EXP_W)) req_if ();
  mexp_rsp_if #(.MOD_WIDTH(MOD_W)) rsp_if ();

  modular_exponentiation_core #(
    .MOD_WIDTH(MOD_W),
    .EXP_WIDTH(EXP_W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .modulus_we_i(modulus_we_i),
    .modulus_i   (modulus_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stall the result channel at random
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check result beats and watch for a stuck channel
  always @(posedge clk_i) begin : monitor
    logic req_beat;
    logic rsp_beat;
    req_beat = rst_ni && req_if.valid && req_if.ready;
    rsp_beat = rst_ni && rsp_if.valid && rsp_if.ready;
    if (rsp_beat) sb.check_result(rsp_if.result);
    if (req_beat || rsp_beat) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d results pending",
               quiet_cycles, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Drive one request beat, idling first at random; note it once accepted
  task automatic send_item(input mexp_op_e op, input logic [BASE_WIDTH-1:0] base,
                           input logic [EXP_W-1:0] exponent);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid    <= 1'b1;
    req_if.op       <= op;
    req_if.base     <= base;
    req_if.exponent <= exponent;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(op, base, exponent);
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_modulus(input logic [MOD_W-1:0] value);
    wait_drained();
    modulus_we_i <= 1'b1;
    modulus_i    <= value;
    @(posedge clk_i);
    modulus_we_i <= 1'b0;
    sb.set_modulus(value);
  endtask

  function automatic logic [EXP_W-1:0] rand_exponent(int unsigned bits);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if (bits < 64) r = r & ((64'd1 << bits) - 64'd1);
    return r[EXP_W-1:0];
  endfunction

  // Mostly short exponents; a few full width ones keep the run short
  function automatic logic [EXP_W-1:0] rand_power_exponent();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return rand_exponent($urandom_range(0, 2));
    if (pick < 70) return rand_exponent($urandom_range(3, 16));
    if (pick < 90) return rand_exponent($urandom_range(17, 40));
    return rand_exponent(EXP_W);
  endfunction

  function automatic logic [BASE_WIDTH-1:0] rand_base(logic [MOD_W-1:0] m);
    logic [63:0] k;
    logic [63:0] prod;
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: begin
        k    = 64'($urandom_range(1, 32'(64'(MOD_MAX) / 64'(m))));
        prod = k * 64'(m);
        return prod[BASE_WIDTH-1:0];
      end
      default: return BASE_WIDTH'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [MOD_W-1:0] set_mod;
    mexp_op_e         op;
    logic [EXP_W-1:0] full_exp;

    sb = new();
    req_if.valid    = 1'b0;
    req_if.op       = OP_POWER;
    req_if.base     = '0;
    req_if.exponent = '0;
    modulus_we_i    = 1'b0;
    modulus_i       = '0;
    send_idle_pct   = 12;
    recv_idle_pct   = 50;
    full_exp        = '1;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes and corner cases at the reset modulus
    send_item(OP_POWER, '0, '0);
    send_item(OP_POWER, '1, '0);
    send_item(OP_POWER, '1, full_exp);
    send_item(OP_POWER, '0, EXP_W'(5));
    send_item(OP_POWER, BASE_WIDTH'(1), full_exp);
    send_item(OP_POWER, MOD_RESET[BASE_WIDTH-1:0], EXP_W'(3));
    send_item(OP_POWER, BASE_WIDTH'(3), EXP_W'(1));
    send_item(OP_POWER, BASE_WIDTH'(2), EXP_W'({(EXP_W + 1) / 2{2'b01}}));
    send_item(OP_INVERSE, BASE_WIDTH'(2), full_exp);
    send_item(OP_INVERSE, '0, EXP_W'(7));
    send_item(OP_INVERSE, MOD_RESET[BASE_WIDTH-1:0], '0);
    send_item(OP_INVERSE, '1, EXP_W'({(EXP_W + 1) / 2{2'b10}}));
    send_item(OP_INVERSE, BASE_WIDTH'(1), '0);

    // Smallest legal modulus: inverse exponent collapses to zero
    write_modulus(MOD_W'(2));
    send_item(OP_POWER, BASE_WIDTH'(3), '0);
    send_item(OP_POWER, BASE_WIDTH'(5), EXP_W'(7));
    send_item(OP_INVERSE, BASE_WIDTH'(2), full_exp);
    send_item(OP_INVERSE, BASE_WIDTH'(3), '0);

    // Largest modulus, not prime
    write_modulus(MOD_MAX);
    send_item(OP_INVERSE, BASE_WIDTH'(12345), '0);
    send_item(OP_POWER, '1, full_exp);

    // Degenerate moduli give zero everywhere
    write_modulus(MOD_W'(1));
    send_item(OP_POWER, BASE_WIDTH'(5), '0);
    send_item(OP_INVERSE, BASE_WIDTH'(5), '0);
    write_modulus('0);
    send_item(OP_POWER, BASE_WIDTH'(7), EXP_W'(3));
    send_item(OP_INVERSE, BASE_WIDTH'(7), '0);

    // Random sets, each under its own modulus; the idling profile steps at sets 2 and 4
    for (int s = 0; s < NUM_SETS; s++) begin
      case (s)
        0: set_mod = MOD_RESET[MOD_W-1:0];
        1: set_mod = PRIME_TOP;
        2: set_mod = MOD_MAX;
        3: set_mod = MOD_W'($urandom_range(2, 32'(MOD_MAX)));
        4: set_mod = PRIME_F4;
        default: set_mod = PRIME_1E9;
      endcase
      write_modulus(set_mod);
      if (s >= 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (s >= 2) begin
        send_idle_pct = 50;
        recv_idle_pct = 12;
      end
      for (int i = 0; i < ITEMS_PER_SET; i++) begin
        // Now and then hold off until the core has emptied
        if ($urandom_range(99) < 4) wait_drained();
        op = ($urandom_range(99) < 30) ? OP_INVERSE : OP_POWER;
        if (op == OP_INVERSE)
          send_item(op, rand_base(set_mod), rand_exponent(EXP_W));
        else
          send_item(op, rand_base(set_mod), rand_power_exponent());
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
sv/mexp_pkg.sv
sv/mexp_ifs.sv
sv/mexp_modmul.sv
sv/modular_exponentiation_core.sv
dv/modular_exponentiation_core_tb.sv
